// File: hw/rtl/tlet_pkg.sv
// Shared types, widths and register codes for the training-load tracker.
package tlet_pkg;

    localparam int LOAD_BITS     = 20;
    localparam int BAL_BITS      = LOAD_BITS + 1;
    localparam int DECAY_BITS    = 16;
    localparam int WIN_BITS      = 7;
    localparam int MAX_WINDOW    = 64;
    localparam int HIST_DEPTH    = MAX_WINDOW + 1;
    localparam int PTR_BITS      = $clog2(HIST_DEPTH);
    localparam int DAY_BITS      = $clog2(MAX_WINDOW + 1);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [LOAD_BITS-1:0]         load_t;
    typedef logic signed [BAL_BITS-1:0]   bal_t;
    typedef logic [DECAY_BITS-1:0]        decay_t;
    typedef logic [WIN_BITS-1:0]          win_t;
    typedef logic [PTR_BITS-1:0]          ptr_t;
    typedef logic [DAY_BITS-1:0]          day_t;
    typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;
    typedef logic [CFG_DATA_BITS-1:0]     cfg_data_t;

    localparam cfg_idx_t CFG_LONG_DECAY    = 2'd0;
    localparam cfg_idx_t CFG_SHORT_DECAY   = 2'd1;
    localparam cfg_idx_t CFG_WINDOW_DAYS   = 2'd2;
    localparam cfg_idx_t CFG_BALANCE_SAME  = 2'd3;

    localparam decay_t LONG_DECAY_RESET  = 16'd63994;
    localparam decay_t SHORT_DECAY_RESET = 16'd56812;
    localparam win_t   WINDOW_RESET      = 7'd7;

endpackage

// File: hw/rtl/tlet_if.sv
// Stream interfaces for the day samples and the per-day results.
interface tlet_in_if;
    logic                      valid;
    logic                      ready;
    logic [tlet_pkg::LOAD_BITS-1:0] daily_stress;
    logic                      seed_valid;
    logic [tlet_pkg::LOAD_BITS-1:0] seed_value;

    modport source (output valid, output daily_stress, output seed_valid,
                     output seed_value, input ready);
    modport sink   (input valid, input daily_stress, input seed_valid,
                     input seed_value, output ready);
endinterface

interface tlet_out_if;
    logic                             valid;
    logic                             ready;
    logic [tlet_pkg::LOAD_BITS-1:0]   long_term_load;
    logic [tlet_pkg::LOAD_BITS-1:0]   short_term_load;
    logic signed [tlet_pkg::BAL_BITS-1:0] stress_balance;
    logic signed [tlet_pkg::BAL_BITS-1:0] ramp_rate;

    modport source (output valid, output long_term_load, output short_term_load,
                     output stress_balance, output ramp_rate, input ready);
    modport sink   (input valid, input long_term_load, input short_term_load,
                     input stress_balance, input ramp_rate, output ready);
endinterface

// File: hw/rtl/tlet_ewma.sv
// One exponential average update with Q0.16 decay, rounded half up.
module tlet_ewma
(
    input  tlet_pkg::load_t  sample,
    input  tlet_pkg::load_t  prev,
    input  tlet_pkg::decay_t decay,
    output tlet_pkg::load_t  avg
);

    localparam int FRAC_BITS = tlet_pkg::DECAY_BITS;
    localparam int ACC_BITS  = tlet_pkg::LOAD_BITS + FRAC_BITS + 2;

    logic [FRAC_BITS:0]  inv_decay;
    logic [ACC_BITS-1:0] acc;

    assign inv_decay = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, decay};

    assign acc = ACC_BITS'(sample) * ACC_BITS'(inv_decay)
               + ACC_BITS'(prev) * ACC_BITS'(decay)
               + ACC_BITS'(1 << (FRAC_BITS - 1));

    // Saturate should the rounded quotient ever pass the load range.
    assign avg = (acc[ACC_BITS-1:FRAC_BITS+tlet_pkg::LOAD_BITS] != '0)
               ? '1 : acc[FRAC_BITS +: tlet_pkg::LOAD_BITS];

endmodule

// File: hw/rtl/training_load_ewma_tracker.sv
// An accepted day beat passes the input stage, then the result stage.
// Throughput: one day per cycle while the result side keeps taking beats.
// The long-average history sits in a 65-entry memory read one stage early.
// Reset clears the averages, day count, history pointer and pending balance,
// and restores the default decays, window and delayed-balance mode.
module training_load_ewma_tracker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  tlet_pkg::cfg_idx_t   cfg_index,
    input  tlet_pkg::cfg_data_t  cfg_data,
    tlet_in_if.sink              in_ch,
    tlet_out_if.source           out_ch
);

    // Configuration registers
    tlet_pkg::decay_t long_decay_reg;
    tlet_pkg::decay_t short_decay_reg;
    tlet_pkg::win_t   window_reg;
    logic             same_day_reg;

    // Input stage
    logic             s1_valid_reg;
    tlet_pkg::load_t  s1_stress_reg;
    logic             s1_seeded_reg;
    tlet_pkg::load_t  s1_seed_reg;

    // Running state
    tlet_pkg::load_t  long_reg;
    tlet_pkg::load_t  short_reg;
    tlet_pkg::load_t  first_long_reg;
    tlet_pkg::day_t   day_count_reg;
    tlet_pkg::ptr_t   ptr_reg;
    tlet_pkg::bal_t   pending_reg;

    // Result stage
    logic             s2_valid_reg;
    tlet_pkg::load_t  s2_long_reg;
    tlet_pkg::load_t  s2_short_reg;
    tlet_pkg::bal_t   s2_bal_reg;
    logic             s2_use_first_reg;
    logic             s2_ramp_zero_reg;
    tlet_pkg::load_t  hist_rd_reg;

    tlet_pkg::load_t  hist_mem [tlet_pkg::HIST_DEPTH];

    tlet_pkg::load_t  long_ewma;
    tlet_pkg::load_t  short_ewma;
    tlet_pkg::load_t  long_next;
    tlet_pkg::load_t  short_next;
    tlet_pkg::bal_t   today_bal;
    tlet_pkg::win_t   win_sat;
    tlet_pkg::ptr_t   rd_addr;
    tlet_pkg::ptr_t   ptr_next;
    tlet_pkg::day_t   day_count_next;
    tlet_pkg::load_t  back_load;
    logic             s1_advance;
    logic             in_take;

    tlet_ewma u_long_ewma
    (
        .sample (s1_stress_reg),
        .prev   (long_reg),
        .decay  (long_decay_reg),
        .avg    (long_ewma)
    );

    tlet_ewma u_short_ewma
    (
        .sample (s1_stress_reg),
        .prev   (short_reg),
        .decay  (short_decay_reg),
        .avg    (short_ewma)
    );

    assign s1_advance   = s1_valid_reg && (!s2_valid_reg || out_ch.ready);
    assign in_ch.ready  = !s1_valid_reg || s1_advance;
    assign in_take      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        long_next  = s1_seeded_reg ? s1_seed_reg : long_ewma;
        short_next = s1_seeded_reg ? s1_seed_reg : short_ewma;
        today_bal  = tlet_pkg::bal_t'(tlet_pkg::BAL_BITS'(long_next)
                   - tlet_pkg::BAL_BITS'(short_next));

        win_sat = (window_reg > tlet_pkg::WIN_BITS'(tlet_pkg::MAX_WINDOW))
                ? tlet_pkg::WIN_BITS'(tlet_pkg::MAX_WINDOW) : window_reg;

        // Ring index of the day that lies one window back, modulo the depth.
        if (tlet_pkg::WIN_BITS'(ptr_reg) >= win_sat)
        begin
            rd_addr = tlet_pkg::PTR_BITS'(tlet_pkg::WIN_BITS'(ptr_reg) - win_sat);
        end
        else
        begin
            rd_addr = tlet_pkg::PTR_BITS'(tlet_pkg::WIN_BITS'(ptr_reg)
                    + tlet_pkg::WIN_BITS'(tlet_pkg::HIST_DEPTH) - win_sat);
        end

        ptr_next = (ptr_reg == tlet_pkg::PTR_BITS'(tlet_pkg::HIST_DEPTH - 1))
                 ? '0 : ptr_reg + 1'b1;
        day_count_next = (day_count_reg < tlet_pkg::DAY_BITS'(tlet_pkg::MAX_WINDOW))
                       ? day_count_reg + 1'b1 : day_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_decay_reg  <= tlet_pkg::LONG_DECAY_RESET;
            short_decay_reg <= tlet_pkg::SHORT_DECAY_RESET;
            window_reg      <= tlet_pkg::WINDOW_RESET;
            same_day_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tlet_pkg::CFG_LONG_DECAY:   long_decay_reg  <= cfg_data;
                tlet_pkg::CFG_SHORT_DECAY:  short_decay_reg <= cfg_data;
                tlet_pkg::CFG_WINDOW_DAYS:  window_reg <= cfg_data[tlet_pkg::WIN_BITS-1:0];
                tlet_pkg::CFG_BALANCE_SAME: same_day_reg    <= cfg_data[0];
                default:                    same_day_reg    <= same_day_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            long_reg       <= '0;
            short_reg      <= '0;
            day_count_reg  <= '0;
            ptr_reg        <= '0;
            pending_reg    <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                s2_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                s2_valid_reg <= 1'b0;
            end

            if (s1_advance)
            begin
                long_reg      <= long_next;
                short_reg     <= short_next;
                day_count_reg <= day_count_next;
                ptr_reg       <= ptr_next;
                pending_reg   <= today_bal;
            end
        end
    end

    // Payload registers and the history memory need no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_stress_reg <= in_ch.daily_stress;
            s1_seeded_reg <= in_ch.seed_valid;
            s1_seed_reg   <= in_ch.seed_value;
        end

        if (s1_advance)
        begin
            // The read happens before this day's own write lands, and every
            // earlier day has already been written, so no bypass is needed.
            hist_mem[ptr_reg] <= long_next;
            hist_rd_reg       <= hist_mem[rd_addr];
            if (day_count_reg == '0)
            begin
                first_long_reg <= long_next;
            end
            s2_long_reg      <= long_next;
            s2_short_reg     <= short_next;
            s2_bal_reg       <= same_day_reg ? today_bal : pending_reg;
            s2_use_first_reg <= tlet_pkg::WIN_BITS'(day_count_reg) < win_sat;
            s2_ramp_zero_reg <= (win_sat == '0);
        end
    end

    // Lookbacks before the first day clamp to the first day's long average.
    assign back_load = s2_ramp_zero_reg ? s2_long_reg
                     : (s2_use_first_reg ? first_long_reg : hist_rd_reg);

    assign out_ch.valid           = s2_valid_reg;
    assign out_ch.long_term_load  = s2_long_reg;
    assign out_ch.short_term_load = s2_short_reg;
    assign out_ch.stress_balance  = s2_bal_reg;
    assign out_ch.ramp_rate       = tlet_pkg::bal_t'(tlet_pkg::BAL_BITS'(s2_long_reg)
                                  - tlet_pkg::BAL_BITS'(back_load));

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the training-load tracker: directed and random day beats.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tlet_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 500000;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam int unsigned RANDOM_PHASES = 10;
    localparam int unsigned DAYS_PER_PHASE = 50;
    localparam int unsigned REPORT_CAP   = 40;

    typedef struct packed {
        load_t long_load;
        load_t short_load;
        bal_t  balance;
        bal_t  ramp;
    } day_result_t;

    // Tracks both averages, the long-average ring and the pending balance, and holds
    // the results still owed by the block in the order the days went in.
    class load_chart_board;
        decay_t      long_decay;
        decay_t      short_decay;
        win_t        window;
        bit          same_day;
        load_t       long_avg;
        load_t       short_avg;
        int unsigned days_seen;
        load_t       long_ring[HIST_DEPTH];
        int unsigned ring_pos;
        bal_t        pending_bal;
        day_result_t owed_days[$];
        int unsigned errors;
        int unsigned checked;

        function new();
            long_decay  = LONG_DECAY_RESET;
            short_decay = SHORT_DECAY_RESET;
            window      = WINDOW_RESET;
            same_day    = 1'b0;
            long_avg    = '0;
            short_avg   = '0;
            days_seen   = 0;
            ring_pos    = 0;
            pending_bal = '0;
            errors      = 0;
            checked     = 0;
            foreach (long_ring[i])
                long_ring[i] = '0;
        endfunction

        function void set_reg(cfg_idx_t idx, cfg_data_t data);
            case (idx)
                CFG_LONG_DECAY:   long_decay  = data;
                CFG_SHORT_DECAY:  short_decay = data;
                CFG_WINDOW_DAYS:  window      = data[WIN_BITS-1:0];
                CFG_BALANCE_SAME: same_day    = data[0];
                default: ;
            endcase
        endfunction

        function load_t blend(load_t sample, load_t prev, decay_t decay);
            logic [63:0] acc;
            acc = 64'(sample) * (64'd65536 - 64'(decay)) + 64'(prev) * 64'(decay) + 64'd32768;
            acc = acc >> 16;
            if (acc > 64'((64'd1 << LOAD_BITS) - 1))
                return '1;
            return acc[LOAD_BITS-1:0];
        endfunction

        function void log_day(load_t stress, logic seeded, load_t seed);
            load_t       back;
            bal_t        today_bal;
            day_result_t r;
            int unsigned w;
            if (seeded)
            begin
                long_avg  = seed;
                short_avg = seed;
            end
            else
            begin
                long_avg  = blend(stress, long_avg, long_decay);
                short_avg = blend(stress, short_avg, short_decay);
            end
            // On the very first day every earlier lookback reads that day's average.
            if (days_seen == 0)
                foreach (long_ring[i])
                    long_ring[i] = long_avg;
            long_ring[ring_pos] = long_avg;
            w = (window > MAX_WINDOW) ? MAX_WINDOW : window;
            back = long_ring[(ring_pos + HIST_DEPTH - w) % HIST_DEPTH];
            r.ramp = {1'b0, long_avg} - {1'b0, back};
            ring_pos = (ring_pos + 1) % HIST_DEPTH;
            today_bal = {1'b0, long_avg} - {1'b0, short_avg};
            r.balance = same_day ? today_bal : pending_bal;
            pending_bal = today_bal;
            if (days_seen < MAX_WINDOW)
                days_seen++;
            r.long_load  = long_avg;
            r.short_load = short_avg;
            owed_days.push_back(r);
        endfunction

        function int unsigned outstanding();
            return owed_days.size();
        endfunction

        function void note_error();
            errors++;
        endfunction

        function bit may_report();
            return errors < REPORT_CAP;
        endfunction

        function void check_day(day_result_t got);
            day_result_t want;
            bit          bad;
            if (owed_days.size() == 0)
            begin
                if (may_report())
                    $display("%0t ns: result beat with nothing owed, got long %0d short %0d",
                             $time, got.long_load, got.short_load);
                note_error();
                return;
            end
            want = owed_days.pop_front();
            checked++;
            bad = 1'b0;
            if (got.long_load !== want.long_load)
            begin
                bad = 1'b1;
                if (may_report())
                    $display("%0t ns: long_term_load expected %0d, got %0d",
                             $time, want.long_load, got.long_load);
            end
            if (got.short_load !== want.short_load)
            begin
                bad = 1'b1;
                if (may_report())
                    $display("%0t ns: short_term_load expected %0d, got %0d",
                             $time, want.short_load, got.short_load);
            end
            if (got.balance !== want.balance)
            begin
                bad = 1'b1;
                if (may_report())
                    $display("%0t ns: stress_balance expected %0d, got %0d",
                             $time, want.balance, got.balance);
            end
            if (got.ramp !== want.ramp)
            begin
                bad = 1'b1;
                if (may_report())
                    $display("%0t ns: ramp_rate expected %0d, got %0d",
                             $time, want.ramp, got.ramp);
            end
            if (bad)
                note_error();
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    tlet_in_if  day_ch();
    tlet_out_if result_ch();

    load_chart_board board = new();

    bit          steady_flow;
    int unsigned hold_requests;
    int unsigned days_sent;
    int unsigned reg_writes;
    int unsigned cycles;

    training_load_ewma_tracker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (day_ch),
        .out_ch    (result_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycles, board.outstanding());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin : watch_results
        day_result_t got;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got.long_load  = result_ch.long_term_load;
            got.short_load = result_ch.short_term_load;
            got.balance    = result_ch.stress_balance;
            got.ramp       = result_ch.ramp_rate;
            board.check_day(got);
        end
    end

    function automatic int unsigned pick_gap(bit steady);
        int unsigned roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // The result side: random runs of ready, with a long hold-off on request.
    initial
    begin : result_pacing
        int unsigned run;
        int unsigned gap;
        int unsigned holds_done;
        holds_done = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            if (hold_requests != holds_done)
            begin
                holds_done++;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                run = $urandom_range(1, 16);
                result_ch.ready <= 1'b1;
                repeat (run) @(posedge clk);
                gap = pick_gap(steady_flow);
                if (gap != 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    function automatic load_t pick_stress();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return load_t'($urandom_range(0, 4095));
            default: return load_t'($urandom());
        endcase
    endfunction

    function automatic cfg_data_t pick_decay();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            2:       return LONG_DECAY_RESET;
            3:       return SHORT_DECAY_RESET;
            4:       return cfg_data_t'(16'hFFFF - $urandom_range(0, 255));
            default: return cfg_data_t'($urandom());
        endcase
    endfunction

    // Narrow registers sometimes get junk in the unused upper bits of the data.
    function automatic cfg_data_t with_junk(cfg_data_t low_bits, int unsigned width);
        cfg_data_t d;
        cfg_data_t mask;
        mask = cfg_data_t'((32'd1 << width) - 1);
        d = ($urandom_range(0, 3) == 0) ? cfg_data_t'($urandom()) : '0;
        return (d & ~mask) | (low_bits & mask);
    endfunction

    function automatic cfg_data_t pick_window();
        win_t w;
        case ($urandom_range(0, 8))
            0:       w = '0;
            1:       w = win_t'(1);
            2:       w = win_t'(2);
            3:       w = win_t'(MAX_WINDOW - 1);
            4:       w = win_t'(MAX_WINDOW);
            5:       w = win_t'(MAX_WINDOW + 1);
            6:       w = '1;
            7:       w = win_t'($urandom_range(1, 10));
            default: w = win_t'($urandom());
        endcase
        return with_junk(cfg_data_t'(w), WIN_BITS);
    endfunction

    task automatic send_day(load_t stress, logic seeded, load_t seed);
        day_ch.valid        <= 1'b1;
        day_ch.daily_stress <= stress;
        day_ch.seed_valid   <= seeded;
        day_ch.seed_value   <= seed;
        do
            @(posedge clk);
        while (day_ch.ready !== 1'b1);
        board.log_day(stress, seeded, seed);
        days_sent++;
    endtask

    task automatic after_day();
        int unsigned gap;
        gap = pick_gap(steady_flow);
        if (gap != 0)
        begin
            day_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_day();
        logic seeded;
        seeded = ($urandom_range(0, 11) == 0);
        send_day(pick_stress(), seeded, pick_stress());
    endtask

    // Stops offering days and waits until every owed result has left the block.
    task automatic drain_results();
        day_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(cfg_data_t long_d, cfg_data_t short_d,
                                cfg_data_t win_d, cfg_data_t mode_d);
        cfg_idx_t  order[4];
        cfg_data_t vals[4];
        int        i;
        order = '{CFG_LONG_DECAY, CFG_SHORT_DECAY, CFG_WINDOW_DAYS, CFG_BALANCE_SAME};
        vals  = '{long_d, short_d, win_d, mode_d};
        drain_results();
        for (i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            board.set_reg(order[i], vals[i]);
            reg_writes++;
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned n;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_LONG_DECAY;
        cfg_data            <= '0;
        day_ch.valid        <= 1'b0;
        day_ch.daily_stress <= '0;
        day_ch.seed_valid   <= 1'b0;
        day_ch.seed_value   <= '0;
        steady_flow         = 1'b0;
        hold_requests       = 0;
        days_sent           = 0;
        reg_writes          = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);

        // Reset settings: a full first day fills the history, then unseeded and seeded days.
        send_day('1, 1'b0, '0);                    after_day();
        send_day('0, 1'b0, '1);                    after_day();
        send_day(load_t'(20'h80), 1'b0, '0);       after_day();
        send_day('1, 1'b1, '0);                    after_day();
        send_day('0, 1'b1, '1);                    after_day();
        send_day('1, 1'b0, '0);                    after_day();

        // Zero long decay tracks the day's stress; zero window gives no ramp.
        program_regs('0, '1, with_junk('0, WIN_BITS), with_junk(cfg_data_t'(1), 1));
        send_day('1, 1'b0, '0);                    after_day();
        send_day('0, 1'b0, '0);                    after_day();
        send_day(pick_stress(), 1'b0, '1);         after_day();
        send_day(pick_stress(), 1'b1, pick_stress()); after_day();

        // A window beyond the history depth saturates at the maximum.
        program_regs('1, '0, cfg_data_t'(win_t'('1)), '0);
        repeat (4)
        begin
            send_random_day();
            after_day();
        end

        program_regs(cfg_data_t'(1), cfg_data_t'(16'hFFFE), cfg_data_t'(MAX_WINDOW), '0);
        repeat (4)
        begin
            send_random_day();
            after_day();
        end

        program_regs(pick_decay(), pick_decay(), cfg_data_t'(1), cfg_data_t'(1));
        repeat (4)
        begin
            send_random_day();
            after_day();
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            program_regs(pick_decay(), pick_decay(), pick_window(),
                         with_junk(cfg_data_t'($urandom_range(0, 1)), 1));
            steady_flow = ($urandom_range(0, 3) == 0);
            // Twice, the result side holds off while days keep coming back to back.
            if (phase == 2 || phase == 7)
            begin
                steady_flow = 1'b1;
                hold_requests++;
            end
            for (n = 0; n < DAYS_PER_PHASE; n++)
            begin
                send_random_day();
                after_day();
            end
        end

        steady_flow = 1'b0;
        day_ch.valid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d day beats across %0d register writes; %0d result beats checked.",
                 days_sent, reg_writes, board.checked);
        $display("Swept zero and full decays, windows from zero past the maximum, both modes.");
        if (board.errors == 0 && board.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: training_load_ewma_tracker.f
hw/rtl/tlet_pkg.sv
hw/rtl/tlet_if.sv
hw/rtl/tlet_ewma.sv
hw/rtl/training_load_ewma_tracker.sv
verif/testbench.sv
